// File: sv/nqfs_pkg.sv
// ----------------------------------------------------------------------------
// nqfs_pkg
// Shared types and constants of the N-queens first-solution search block.
// ----------------------------------------------------------------------------
package nqfs_pkg;

   // Row and column fields are four bits wide, which caps the board size.
   localparam int FIELD_LIMIT = 16;
   localparam int SIZE_W      = 5;
   localparam int ROW_W       = 4;
   localparam int COL_W       = 4;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TRY,
      S_POP,
      S_OUT_RD,
      S_OUT,
      S_FAIL
   } state_type;

   // Operation requested of the occupancy checker in one cycle.
   typedef struct packed {
      logic clear_all;
      logic place;
      logic remove;
   } chk_op_type;

endpackage

// File: sv/n_queens_first_solution.sv
// ----------------------------------------------------------------------------
// n_queens_first_solution
// Depth-first backtracking search for the lexicographically first N-queens
// placement; one result item per row, or a single not-found item.
// ----------------------------------------------------------------------------
// Each trial square is tested in the conflict checker; a backtrack reads the
// stack entry of the row above, then unplaces it; each result item is read
// from the stack, then held on the output until rsp_ready takes it.
// Throughput: one search at a time; req_ready is high only when idle.
// Reset clears the sequencer and the occupancy masks; the column stack is
// not cleared, since every search writes an entry before reading it.
// ----------------------------------------------------------------------------
module n_queens_first_solution
   import nqfs_pkg::*;
#(
   parameter int MAX_N = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [SIZE_W-1:0] req_board_size,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ROW_W-1:0]  rsp_row_index,
   output logic [COL_W-1:0]  rsp_queen_column,
   output logic              rsp_found,
   output logic              rsp_last
);

   localparam int LIMIT = (MAX_N < FIELD_LIMIT) ? MAX_N : FIELD_LIMIT;
   localparam int CW    = $clog2(LIMIT);
   localparam int RW    = $clog2(LIMIT + 1);

   state_type     state_ff, state_in;
   logic [RW-1:0] n_ff, n_in;
   logic [RW-1:0] row_ff, row_in;
   logic [RW-1:0] trial_ff, trial_in;
   logic [CW-1:0] out_row_ff, out_row_in;

   logic [RW-1:0] row_m1;
   logic [RW-1:0] size_sat;
   logic          out_last;

   chk_op_type    chk_op;
   logic [CW-1:0] chk_row;
   logic [CW-1:0] chk_col;
   logic          chk_fits;

   logic          stk_wr_en;
   logic          stk_rd_en;
   logic [CW-1:0] stk_rd_addr;
   logic [CW-1:0] stk_rd_data;

   assign row_m1   = row_ff - RW'(1);
   assign size_sat = (int'(req_board_size) > LIMIT) ? RW'(LIMIT) : RW'(req_board_size);
   assign out_last = (RW'(out_row_ff) + RW'(1)) == n_ff;

   nqfs_check #(
      .LIMIT (LIMIT),
      .CW    (CW)
   ) u_check (
      .clock (clock),
      .reset (reset),
      .op    (chk_op),
      .row   (chk_row),
      .col   (chk_col),
      .fits  (chk_fits)
   );

   nqfs_stack #(
      .DEPTH (LIMIT),
      .AW    (CW),
      .DW    (CW)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (row_ff[CW-1:0]),
      .wr_data (trial_ff[CW-1:0]),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   always_comb begin
      state_in    = state_ff;
      n_in        = n_ff;
      row_in      = row_ff;
      trial_in    = trial_ff;
      out_row_in  = out_row_ff;
      chk_op      = '0;
      chk_row     = row_ff[CW-1:0];
      chk_col     = trial_ff[CW-1:0];
      stk_wr_en   = 1'b0;
      stk_rd_en   = 1'b0;
      stk_rd_addr = row_m1[CW-1:0];
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               chk_op.clear_all = 1'b1;
               n_in             = size_sat;
               row_in           = '0;
               trial_in         = '0;
               state_in         = (size_sat == '0) ? S_FAIL : S_TRY;
            end
         end
         S_TRY: begin
            if (row_ff == n_ff) begin
               out_row_in = '0;
               state_in   = S_OUT_RD;
            end else if (trial_ff == n_ff) begin
               if (row_ff == '0) begin
                  state_in = S_FAIL;
               end else begin
                  // Fetch the queen of the row above to resume after it.
                  stk_rd_en = 1'b1;
                  state_in  = S_POP;
               end
            end else if (chk_fits) begin
               chk_op.place = 1'b1;
               stk_wr_en    = 1'b1;
               row_in       = row_ff + RW'(1);
               trial_in     = '0;
            end else begin
               trial_in = trial_ff + RW'(1);
            end
         end
         S_POP: begin
            chk_op.remove = 1'b1;
            chk_row       = row_m1[CW-1:0];
            chk_col       = stk_rd_data;
            row_in        = row_m1;
            trial_in      = RW'(stk_rd_data) + RW'(1);
            state_in      = S_TRY;
         end
         S_OUT_RD: begin
            stk_rd_en   = 1'b1;
            stk_rd_addr = out_row_ff;
            state_in    = S_OUT;
         end
         S_OUT: begin
            rsp_valid   = 1'b1;
            stk_rd_addr = out_row_ff;
            if (rsp_ready) begin
               if (out_last) begin
                  state_in = S_IDLE;
               end else begin
                  out_row_in = out_row_ff + CW'(1);
                  state_in   = S_OUT_RD;
               end
            end
         end
         S_FAIL: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         n_ff       <= '0;
         row_ff     <= '0;
         trial_ff   <= '0;
         out_row_ff <= '0;
      end else begin
         state_ff   <= state_in;
         n_ff       <= n_in;
         row_ff     <= row_in;
         trial_ff   <= trial_in;
         out_row_ff <= out_row_in;
      end
   end

   assign rsp_row_index    = (state_ff == S_OUT) ? ROW_W'(out_row_ff) : '0;
   assign rsp_queen_column = (state_ff == S_OUT) ? COL_W'(stk_rd_data) : '0;
   assign rsp_found        = (state_ff == S_OUT);
   assign rsp_last         = (state_ff == S_FAIL) || ((state_ff == S_OUT) && out_last);

endmodule

// File: sv/nqfs_stack.sv
// ----------------------------------------------------------------------------
// nqfs_stack
// Column stack of the search: one write port and one registered read port.
// ----------------------------------------------------------------------------
module nqfs_stack #(
   parameter int DEPTH = 16,
   parameter int AW    = 4,
   parameter int DW    = 4
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read data holds while rd_en is low, so a result stays stable under stall.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/nqfs_check.sv
// ----------------------------------------------------------------------------
// nqfs_check
// Occupancy masks for columns and both diagonals, with the conflict test that
// the sequencer applies to every trial square.
// ----------------------------------------------------------------------------
module nqfs_check
   import nqfs_pkg::*;
#(
   parameter int LIMIT = 16,
   parameter int CW    = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  chk_op_type    op,
   input  logic [CW-1:0] row,
   input  logic [CW-1:0] col,
   output logic          fits
);

   localparam int DIAGS = 2 * LIMIT - 1;
   localparam int DIW   = $clog2(DIAGS);

   logic [LIMIT-1:0] col_mask_ff, col_mask_in;
   logic [DIAGS-1:0] sum_mask_ff, sum_mask_in;
   logic [DIAGS-1:0] dif_mask_ff, dif_mask_in;
   logic [DIW-1:0]   sum_idx;
   logic [DIW-1:0]   dif_idx;

   assign sum_idx = DIW'(row) + DIW'(col);
   // Offset keeps the difference-diagonal index non-negative.
   assign dif_idx = DIW'(row) + DIW'(LIMIT - 1) - DIW'(col);

   assign fits = !col_mask_ff[col] && !sum_mask_ff[sum_idx] && !dif_mask_ff[dif_idx];

   always_comb begin
      col_mask_in = col_mask_ff;
      sum_mask_in = sum_mask_ff;
      dif_mask_in = dif_mask_ff;
      if (op.clear_all) begin
         col_mask_in = '0;
         sum_mask_in = '0;
         dif_mask_in = '0;
      end else if (op.place) begin
         col_mask_in[col]     = 1'b1;
         sum_mask_in[sum_idx] = 1'b1;
         dif_mask_in[dif_idx] = 1'b1;
      end else if (op.remove) begin
         col_mask_in[col]     = 1'b0;
         sum_mask_in[sum_idx] = 1'b0;
         dif_mask_in[dif_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_mask_ff <= '0;
         sum_mask_ff <= '0;
         dif_mask_ff <= '0;
      end else begin
         col_mask_ff <= col_mask_in;
         sum_mask_ff <= sum_mask_in;
         dif_mask_ff <= dif_mask_in;
      end
   end

endmodule

// File: sim/tb_n_queens_first_solution.sv
// ----------------------------------------------------------------------------
// tb_n_queens_first_solution
// Feeds board sizes to the N-queens search block and compares every result
// item with a backtracking search run in the testbench, under random stalls
// on both the request and the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_n_queens_first_solution;
   import nqfs_pkg::*;

   localparam int MAX_N          = 16;
   localparam int SIZE_CAP       = (MAX_N < FIELD_LIMIT) ? MAX_N : FIELD_LIMIT;
   localparam int WATCHDOG_LIMIT = 2000000;
   localparam int REPORT_LIMIT   = 10;
   localparam int RANDOM_ITEMS   = 82;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] column;
      logic             found;
      logic             last;
   } placement_type;

   class queens_scoreboard;
      placement_type expected_rows[$];
      int            errors;

      function new();
         errors = 0;
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= REPORT_LIMIT) $display("%s", msg);
      endfunction

      // Depth-first search with an explicit column stack; columns are tried
      // from left to right so the first hit is the lexicographic minimum.
      function void note_board(logic [SIZE_W-1:0] size);
         int            n;
         int            row;
         int            col;
         int            r;
         int            col_gap;
         int            stack[FIELD_LIMIT];
         bit            solved;
         bit            done;
         bit            free_square;
         placement_type item;
         n = size;
         if (n > SIZE_CAP) n = SIZE_CAP;
         row    = 0;
         col    = 0;
         solved = 1'b0;
         done   = (n == 0);
         while (!done) begin
            if (row >= n) begin
               solved = 1'b1;
               done   = 1'b1;
            end else if (col >= n) begin
               if (row == 0) begin
                  done = 1'b1;
               end else begin
                  row--;
                  col = stack[row] + 1;
               end
            end else begin
               free_square = 1'b1;
               for (r = 0; r < row; r++) begin
                  col_gap = (stack[r] > col) ? stack[r] - col : col - stack[r];
                  if (stack[r] == col || row - r == col_gap) free_square = 1'b0;
               end
               if (free_square) begin
                  stack[row] = col;
                  row++;
                  col = 0;
               end else begin
                  col++;
               end
            end
         end
         if (solved) begin
            for (r = 0; r < n; r++) begin
               item.row    = r[ROW_W-1:0];
               item.column = stack[r][COL_W-1:0];
               item.found  = 1'b1;
               item.last   = (r == n - 1);
               expected_rows.push_back(item);
            end
         end else begin
            item = '{row: '0, column: '0, found: 1'b0, last: 1'b1};
            expected_rows.push_back(item);
         end
      endfunction

      function void check_result(logic [ROW_W-1:0] row, logic [COL_W-1:0] column,
                                 logic found, logic last);
         placement_type want;
         if (expected_rows.size() == 0) begin
            flag($sformatf("Unexpected result item: row %0d column %0d found %0b last %0b",
                           row, column, found, last));
            return;
         end
         want = expected_rows.pop_front();
         if (row !== want.row)
            flag($sformatf("row_index mismatch: expected %0d, got %0d", want.row, row));
         if (column !== want.column)
            flag($sformatf("queen_column mismatch at row %0d: expected %0d, got %0d",
                           want.row, want.column, column));
         if (found !== want.found)
            flag($sformatf("found mismatch at row %0d: expected %0b, got %0b",
                           want.row, want.found, found));
         if (last !== want.last)
            flag($sformatf("last mismatch at row %0d: expected %0b, got %0b",
                           want.row, want.last, last));
      endfunction

      function int pending();
         return expected_rows.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [SIZE_W-1:0] req_board_size = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [ROW_W-1:0]  rsp_row_index;
   logic [COL_W-1:0]  rsp_queen_column;
   logic              rsp_found;
   logic              rsp_last;

   // When set, neither side inserts wait cycles.
   bit               steady = 1'b0;
   int               stall_count = 0;
   queens_scoreboard board_log = new();

   n_queens_first_solution #(
      .MAX_N(MAX_N)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_board_size   (req_board_size),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_row_index    (rsp_row_index),
      .rsp_queen_column (rsp_queen_column),
      .rsp_found        (rsp_found),
      .rsp_last         (rsp_last)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         stall_count <= 0;
      end else begin
         if (req_valid && req_ready) board_log.note_board(req_board_size);
         if (rsp_valid && rsp_ready)
            board_log.check_result(rsp_row_index, rsp_queen_column, rsp_found, rsp_last);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_count <= 0;
         end else if (stall_count >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end else begin
            stall_count <= stall_count + 1;
         end
      end
   end

   function int draw_gap();
      return steady ? 0 : $urandom_range(0, 4);
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_board(int size);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_board_size <= size[SIZE_W-1:0];
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   initial begin
      int gap;
      while (reset) @(negedge clock);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin
      int directed_sizes[18];
      int pick;
      int size;
      directed_sizes = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15,
                         16, 31};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_sizes[i]) send_board(directed_sizes[i]);

      // Sizes above the cap all run the slowest search, so they stay rare.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         steady = ((i / 16) % 2) == 1;
         pick   = $urandom_range(0, 99);
         if (pick == 0)     size = $urandom_range(16, 31);
         else if (pick < 5) size = $urandom_range(13, 15);
         else               size = $urandom_range(0, 12);
         send_board(size);
      end
      req_valid <= 1'b0;
      steady = 1'b0;

      while (board_log.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board_log.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
